// ===== sv/tma_pkg.sv =====
package tma_pkg;

  // Width of the window length register.
  localparam int CFG_W = 9;

  // Depth of the queue between the front and the divider.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  typedef struct packed {
    logic               empty;
    logic [Q_PTR_W:0]   count;
  } tma_qstat_t;

endpackage

// ===== sv/tma_queue.sv =====
module tma_queue
  import tma_pkg::*;
#(
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output tma_qstat_t    qstat
);

  logic [DW-1:0]      mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic [Q_PTR_W:0]   cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign pop_data    = mem_r[rd_ptr_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.count = cnt_r;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == (Q_PTR_W+1)'(Q_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue read while empty");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a write");

  a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count did not follow a read");
`endif

endmodule

// ===== sv/tma_front.sv =====
module tma_front
  import tma_pkg::*;
#(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int LEN_W       = 9,
  parameter int SUM_W       = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_start_req,
  input  logic                   clear,
  input  logic [LEN_W-1:0]       len,
  input  tma_qstat_t             qstat,
  output logic                   push,
  output logic [SUM_W-1:0]       push_data
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [SAMPLE_BITS-1:0] hist_r [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_r;
  logic [AW-1:0]          wp_r;
  logic [AW-1:0]          wp_nxt;
  logic [LEN_W-1:0]       fill_r;
  logic [LEN_W-1:0]       fill_eff;
  logic [LEN_W-1:0]       fill_nxt;
  logic                   full;
  logic                   acc;
  logic [LEN_W:0]         old_tmp;
  logic [AW-1:0]          old_addr;

  logic                   s2_v_r;
  logic                   s2_start_r;
  logic                   s2_full_r;
  logic                   s2_emit_r;
  logic [SAMPLE_BITS-1:0] s2_sample_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic [Q_PTR_W:0]       pending;

  // Keep a slot free for the beat that is still in the second stage.
  assign pending  = qstat.count + (Q_PTR_W+1)'(s2_v_r && s2_emit_r);
  assign in_stall = (pending >= (Q_PTR_W+1)'(Q_DEPTH));
  assign acc      = in_valid && !in_stall;

  always_comb begin
    fill_eff = in_start_req ? '0 : fill_r;
    full     = (fill_eff >= len);
    fill_nxt = full ? len : fill_eff + 1'b1;
    wp_nxt   = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
    old_tmp  = (LEN_W+1)'(wp_r) + (LEN_W+1)'(MAX_WINDOW) - (LEN_W+1)'(len);
    if (old_tmp >= (LEN_W+1)'(MAX_WINDOW)) begin
      old_tmp = old_tmp - (LEN_W+1)'(MAX_WINDOW);
    end
    old_addr = AW'(old_tmp);
  end

  // The read sees the entry before this beat's write, which matters when the
  // window spans the whole delay line.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r         <= hist_r[old_addr];
      hist_r[wp_r] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= acc;
      if (clear) begin
        fill_r <= '0;
      end else if (acc) begin
        fill_r <= fill_nxt;
        wp_r   <= wp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s2_sample_r <= in_sample;
      s2_start_r  <= in_start_req;
      s2_full_r   <= full;
      s2_emit_r   <= (fill_nxt == len);
    end
  end

  always_comb begin
    sum_nxt = s2_start_r ? '0 : sum_r;
    if (s2_full_r) begin
      sum_nxt = sum_nxt - SUM_W'(rd_r);
    end
    sum_nxt = sum_nxt + SUM_W'(s2_sample_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (clear) begin
      sum_r <= '0;
    end else if (s2_v_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign push      = s2_v_r && s2_emit_r;
  assign push_data = sum_nxt;

endmodule

// ===== sv/tma_div_back.sv =====
module tma_div_back
  import tma_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int LEN_W       = 9,
  parameter int SUM_W       = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [LEN_W-1:0]       len,
  input  tma_qstat_t             qstat,
  input  logic [SUM_W-1:0]       pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_average
);

  localparam int STEP_W = $clog2(SAMPLE_BITS + 1);

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DONE
  } bstate_t;

  bstate_t                state_r;
  logic [LEN_W-1:0]       rem_r;
  logic [SAMPLE_BITS-1:0] quo_r;
  logic [STEP_W-1:0]      step_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_average_r;

  logic [LEN_W:0]         trial;
  logic                   ge;
  logic [LEN_W-1:0]       rem_nxt;
  logic [SAMPLE_BITS:0]   quo_ext;
  logic [SAMPLE_BITS-1:0] quo_nxt;

  // Restoring division, one quotient bit a cycle. The quotient fits the
  // sample width, so the bits above it start as the partial remainder.
  always_comb begin
    trial   = {rem_r, quo_r[SAMPLE_BITS-1]};
    ge      = (trial >= {1'b0, len});
    rem_nxt = ge ? LEN_W'(trial - {1'b0, len}) : LEN_W'(trial);
    quo_ext = {quo_r, ge};
    quo_nxt = quo_ext[SAMPLE_BITS-1:0];
  end

  assign pop = (state_r == B_IDLE) && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!qstat.empty) begin
            rem_r   <= LEN_W'(pop_data >> SAMPLE_BITS);
            quo_r   <= pop_data[SAMPLE_BITS-1:0];
            step_r  <= '0;
            state_r <= B_RUN;
          end
        end
        B_RUN: begin
          rem_r  <= rem_nxt;
          quo_r  <= quo_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(SAMPLE_BITS - 1)) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_average_r <= quo_r;
            state_r       <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

endmodule

// ===== sv/trailing_moving_average.sv =====
// Throughput: one sample a cycle is taken until the four-entry queue fills. Averages
// leave the bit-serial divider one at a time: it pops the next sum only after it has
// handed the last average to the output register. Beats that yield no average pass at
// one a cycle while in_stall is low.
// Reset (rst_n, synchronous, active low) clears sum, fill count, pointers and the
// queue, and sets the window length to 1; the delay line is not cleared.
module trailing_moving_average
  import tma_pkg::*;
#(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_start_req,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_average,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CW    = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  logic [CFG_W-1:0] wlen_r;
  logic [CW-1:0]    wlen_ext;
  logic [LEN_W-1:0] len;
  logic             push;
  logic [SUM_W-1:0] push_data;
  logic             pop;
  logic [SUM_W-1:0] pop_data;
  tma_qstat_t       qstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      wlen_r <= cfg_wr_data;
    end
  end

  // A length of zero acts as one; lengths above the delay line saturate.
  always_comb begin
    wlen_ext = CW'(wlen_r);
    if (wlen_ext == '0) begin
      len = LEN_W'(1);
    end else if (wlen_ext > CW'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(wlen_ext);
    end
  end

  tma_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .in_start_req (in_start_req),
    .clear        (cfg_wr_en),
    .len          (len),
    .qstat        (qstat),
    .push         (push),
    .push_data    (push_data)
  );

  tma_queue #(
    .DW (SUM_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  tma_div_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LEN_W       (LEN_W),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .len         (len),
    .qstat       (qstat),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average)
  );

endmodule
